>>> design/bhcb_pkg.sv
package bhcb_pkg;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 80;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 64;
   localparam int PORT_TAG_W  = 64;
   localparam int STEP_W      = 8;
   localparam int CAP_REG_W   = 7;
   localparam int CURSOR_OUT_W = 6;
   localparam int COUNT_OUT_W  = 7;

   typedef logic [1:0] action_type;
   localparam action_type ACT_VISIT   = 2'd0;
   localparam action_type ACT_BACK    = 2'd1;
   localparam action_type ACT_FORWARD = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_HOME_TAG = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY = 8'd1;

   typedef logic [1:0] tag_src_type;
   localparam tag_src_type SRC_STORE = 2'd0;
   localparam tag_src_type SRC_HOME  = 2'd1;
   localparam tag_src_type SRC_VISIT = 2'd2;

endpackage

>>> design/bhcb_store.sv
module bhcb_store #(
   parameter int DEPTH     = 64,
   parameter int TAG_WIDTH = 64
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [TAG_WIDTH-1:0]         wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [TAG_WIDTH-1:0]         rd_data
);

   logic [TAG_WIDTH-1:0] mem [DEPTH];
   logic [TAG_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/bounded_history_cursor_buffer_core.sv
// Bounded page history with a cursor, kept as a ring in a single-port-write,
// registered-read store. Each request word (visit, back or forward) returns one
// response word with the tag under the cursor, the cursor position and the entry
// count. On acceptance a request updates the ring pointers, writes the store on
// a visit and issues the store read; the result then moves into the response
// register once that register is empty or being taken, and no new request is
// accepted until it has moved. A visited tag is forwarded straight to the
// response, and slot 0 reads the home tag until a visit first overwrites it.
// There is no clearing pass after reset. Configuration writes are always taken
// and must only be issued while no request is in flight.
module bounded_history_cursor_buffer_core #(
   parameter int DEPTH     = 64,
   parameter int TAG_WIDTH = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // page_tag[63:0], step_count[71:64]
   input  logic [bhcb_pkg::REQ_TDATA_W-1:0]       req_tdata,
   // action[1:0]
   input  bhcb_pkg::action_type                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // current_tag[63:0], cursor_position[69:64], entry_count[76:70], zero pad
   output logic [bhcb_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bhcb_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [bhcb_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CW    = (CNT_W > bhcb_pkg::CAP_REG_W) ? CNT_W : bhcb_pkg::CAP_REG_W;
   localparam int SW    = ((PTR_W > bhcb_pkg::STEP_W) ? PTR_W : bhcb_pkg::STEP_W) + 1;

   function automatic logic [PTR_W-1:0] ring_slot(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] offset);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   logic [TAG_WIDTH-1:0]         home_tag_ff;
   logic [bhcb_pkg::CAP_REG_W-1:0] capacity_ff;
   logic [PTR_W-1:0]             oldest_ff, oldest_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [PTR_W-1:0]             cursor_ff, cursor_in;
   logic                         home_unwritten_ff, home_unwritten_in;
   logic                         pending_ff;
   bhcb_pkg::tag_src_type        src_ff, src_in;
   logic [TAG_WIDTH-1:0]         visit_tag_ff;
   logic                         rsp_tvalid_ff;
   logic [bhcb_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff;

   bhcb_pkg::action_type         action;
   logic [TAG_WIDTH-1:0]         page_tag;
   logic [bhcb_pkg::STEP_W-1:0]  step_count;
   logic                         req_accept, rsp_load;

   logic [CW-1:0]                cap_wide;
   logic [CNT_W-1:0]             cap_eff;
   logic [CNT_W-1:0]             kept;
   logic [SW-1:0]                target, last_pos;
   logic                         wr_en;
   logic [PTR_W-1:0]             wr_addr, rd_addr;
   logic [TAG_WIDTH-1:0]         rd_data;
   logic [TAG_WIDTH-1:0]         result_tag;
   logic [31:0]                  cursor_wide, count_wide;

   assign action     = req_tuser;
   assign page_tag   = req_tdata[0 +: TAG_WIDTH];
   assign step_count = req_tdata[bhcb_pkg::PORT_TAG_W +: bhcb_pkg::STEP_W];

   assign req_tready = !pending_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_load   = pending_ff && (!rsp_tvalid_ff || rsp_tready);
   assign csr_ready  = 1'b1;

   always_comb begin
      cap_wide = CW'(capacity_ff);
      if (cap_wide < CW'(2)) begin
         cap_wide = CW'(2);
      end
      if (cap_wide > CW'(DEPTH)) begin
         cap_wide = CW'(DEPTH);
      end
      cap_eff = cap_wide[CNT_W-1:0];
   end

   always_comb begin
      oldest_in         = oldest_ff;
      count_in          = count_ff;
      cursor_in         = cursor_ff;
      home_unwritten_in = home_unwritten_ff;
      wr_en             = 1'b0;
      wr_addr           = ring_slot(oldest_ff, CNT_W'(cursor_ff));
      kept              = CNT_W'(cursor_ff) + CNT_W'(1);
      target            = SW'(cursor_ff) + SW'(step_count);
      last_pos          = SW'(count_ff) - SW'(1);
      unique case (action)
         bhcb_pkg::ACT_VISIT: begin
            if (kept > count_ff) begin
               kept = count_ff;
            end
            if (kept >= cap_eff) begin
               oldest_in = ring_slot(oldest_ff, kept - (cap_eff - CNT_W'(1)));
               kept      = cap_eff - CNT_W'(1);
            end
            wr_addr   = ring_slot(oldest_in, kept);
            wr_en     = req_accept;
            count_in  = kept + CNT_W'(1);
            cursor_in = kept[PTR_W-1:0];
            if (wr_addr == '0) begin
               home_unwritten_in = 1'b0;
            end
         end
         bhcb_pkg::ACT_BACK: begin
            if (SW'(cursor_ff) >= SW'(step_count)) begin
               cursor_in = cursor_ff - PTR_W'(step_count);
            end else begin
               cursor_in = '0;
            end
         end
         bhcb_pkg::ACT_FORWARD: begin
            if (target > last_pos) begin
               cursor_in = last_pos[PTR_W-1:0];
            end else begin
               cursor_in = target[PTR_W-1:0];
            end
         end
         default: begin
         end
      endcase
      rd_addr = ring_slot(oldest_in, CNT_W'(cursor_in));
      if (action == bhcb_pkg::ACT_VISIT) begin
         src_in = bhcb_pkg::SRC_VISIT;
      end else if (rd_addr == '0 && home_unwritten_ff) begin
         src_in = bhcb_pkg::SRC_HOME;
      end else begin
         src_in = bhcb_pkg::SRC_STORE;
      end
   end

   bhcb_store #(
      .DEPTH     (DEPTH),
      .TAG_WIDTH (TAG_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (page_tag),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         home_tag_ff <= '0;
         capacity_ff <= bhcb_pkg::CAP_REG_W'(64);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == bhcb_pkg::CSR_HOME_TAG) begin
            home_tag_ff <= csr_data[TAG_WIDTH-1:0];
         end else if (csr_index == bhcb_pkg::CSR_CAPACITY) begin
            capacity_ff <= csr_data[bhcb_pkg::CAP_REG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff         <= '0;
         count_ff          <= CNT_W'(1);
         cursor_ff         <= '0;
         home_unwritten_ff <= 1'b1;
         pending_ff        <= 1'b0;
         src_ff            <= bhcb_pkg::SRC_STORE;
      end else begin
         if (req_accept) begin
            oldest_ff         <= oldest_in;
            count_ff          <= count_in;
            cursor_ff         <= cursor_in;
            home_unwritten_ff <= home_unwritten_in;
            src_ff            <= src_in;
            pending_ff        <= 1'b1;
         end else if (rsp_load) begin
            pending_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         visit_tag_ff <= page_tag;
      end
   end

   always_comb begin
      case (src_ff)
         bhcb_pkg::SRC_VISIT: result_tag = visit_tag_ff;
         bhcb_pkg::SRC_HOME:  result_tag = home_tag_ff;
         default:             result_tag = rd_data;
      endcase
      cursor_wide = 32'(cursor_ff);
      count_wide  = 32'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tdata_ff <= {3'b000, count_wide[bhcb_pkg::COUNT_OUT_W-1:0],
                          cursor_wide[bhcb_pkg::CURSOR_OUT_W-1:0],
                          bhcb_pkg::PORT_TAG_W'(result_tag)};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(cursor_ff) < count_ff)
      else $error("cursor beyond last kept entry");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CNT_W'(1) && count_ff <= CNT_W'(DEPTH))
      else $error("entry count out of range");

   a_accept_pends: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> pending_ff)
      else $error("accepted request not pending");

   a_pending_holds: assert property (@(posedge clock) disable iff (reset)
      pending_ff && !rsp_load |=> pending_ff && $stable(src_ff) && $stable(cursor_ff))
      else $error("stalled request changed state");

endmodule
